/* hw/rtl/frma_pkg.sv */
// ----------------------------------------------------------------------------
// frma_pkg: shared types and constants of the frame RMS level meter
// Field widths, the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package frma_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 16;
    localparam int OFFSET_W = 15;
    localparam int SUM_W    = 44;
    localparam int ROOT_W   = 22;

    // Controller to datapath commands
    typedef struct packed {
        logic accumulate;
        logic div_start;
        logic div_step;
        logic sqrt_start;
        logic sqrt_step;
        logic ring_update;
        logic avg_start;
        logic avg_step;
        logic out_load;
    } frma_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic frame_close;
        logic div_done;
        logic sqrt_done;
        logic avg_done;
    } frma_status_t;

endpackage

/* hw/rtl/frma_ctrl.sv */
// ----------------------------------------------------------------------------
// frma_ctrl: sequencer of the level meter
// Steps accumulate, divide, square root, ring update, average and output.
// ----------------------------------------------------------------------------
module frma_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  out_busy,
    input  frma_pkg::frma_status_t status,
    output frma_pkg::frma_cmd_t   cmd
);
    import frma_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_CHK  = 7'b0000010,
        ST_DIV  = 7'b0000100,
        ST_SQRT = 7'b0001000,
        ST_RING = 7'b0010000,
        ST_AVG  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accumulate = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (status.frame_close) begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    cmd.sqrt_start = 1'b1;
                    state_next = ST_SQRT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_SQRT: begin
                if (status.sqrt_done) begin
                    state_next = ST_RING;
                end else begin
                    cmd.sqrt_step = 1'b1;
                end
            end
            ST_RING: begin
                cmd.ring_update = 1'b1;
                cmd.avg_start   = 1'b1;
                state_next = ST_AVG;
            end
            ST_AVG: begin
                if (status.avg_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.avg_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (!out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* hw/rtl/frma_datapath.sv */
// ----------------------------------------------------------------------------
// frma_datapath: arithmetic of the level meter
// Square accumulator, restoring divider, digit square root, level ring,
// average divider and output register.
// ----------------------------------------------------------------------------
module frma_datapath #(
    parameter int AVG_DEPTH = 16,
    parameter int FRAME_MAX = 512
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic signed [frma_pkg::SAMPLE_W-1:0] in_sample,
    input  logic                           in_last,
    input  logic [frma_pkg::OFFSET_W-1:0]  dc_offset,
    input  frma_pkg::frma_cmd_t            cmd,
    output frma_pkg::frma_status_t         status,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [55:0]                    m_tdata,
    output logic                           out_busy
);
    import frma_pkg::*;

    localparam int CNT_W  = $clog2(FRAME_MAX + 1);
    localparam int POS_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int FILL_W = $clog2(AVG_DEPTH + 1);
    localparam int TOT_W  = LEVEL_W + $clog2(AVG_DEPTH + 1);
    localparam int DIV_W  = SUM_W;   // quotient bits of the mean divider
    localparam int DSTEP_W = $clog2(DIV_W + 1);
    localparam int SSTEP_W = $clog2(ROOT_W + 1);
    localparam int ASTEP_W = $clog2(TOT_W + 1);

    // Frame accumulator
    logic [SUM_W-1:0] square_sum_reg;
    logic [CNT_W-1:0] count_reg;
    logic             close_reg;
    logic [SAMPLE_W:0] mag;
    logic [2*SAMPLE_W+1:0] mag_sq;
    logic [SUM_W-1:0]  sq;
    logic [CNT_W-1:0]  count_inc;

    assign mag = in_sample[SAMPLE_W-1] ? (SAMPLE_W+1)'(-$signed({in_sample[SAMPLE_W-1],
                 in_sample})) : {1'b0, in_sample};
    assign mag_sq = mag * mag;
    assign sq  = SUM_W'(mag_sq);
    assign count_inc = count_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            square_sum_reg <= '0;
            count_reg      <= '0;
            close_reg      <= 1'b0;
        end else if (cmd.accumulate) begin
            square_sum_reg <= square_sum_reg + sq;
            count_reg      <= count_inc;
            close_reg      <= in_last || (32'(count_inc) >= FRAME_MAX);
        end else if (cmd.div_start) begin
            square_sum_reg <= '0;
            count_reg      <= '0;
        end
    end

    // Restoring divider: mean = sum / count, one quotient bit a cycle
    logic [SUM_W-1:0]   dq_reg;
    logic [CNT_W:0]     drem_reg;
    logic [CNT_W-1:0]   dden_reg;
    logic [DSTEP_W-1:0] dstep_reg;
    logic [CNT_W:0]     dtrial;

    assign dtrial = {drem_reg[CNT_W-1:0], dq_reg[SUM_W-1]};

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dq_reg    <= square_sum_reg;
            drem_reg  <= '0;
            dden_reg  <= count_reg;
            dstep_reg <= '0;
        end else if (cmd.div_step) begin
            if (dtrial >= {1'b0, dden_reg}) begin
                drem_reg <= dtrial - {1'b0, dden_reg};
                dq_reg   <= {dq_reg[SUM_W-2:0], 1'b1};
            end else begin
                drem_reg <= dtrial;
                dq_reg   <= {dq_reg[SUM_W-2:0], 1'b0};
            end
            dstep_reg <= dstep_reg + 1'b1;
        end
    end

    assign status.frame_close = close_reg;
    assign status.div_done    = (32'(dstep_reg) == DIV_W);

    // Digit square root, two radicand bits a cycle
    logic [2*ROOT_W-1:0] srad_reg;
    logic [ROOT_W+1:0]   srem_reg;
    logic [ROOT_W-1:0]   sroot_reg;
    logic [SSTEP_W-1:0]  sstep_reg;
    logic [ROOT_W+1:0]   strial, stest;

    assign strial = {srem_reg[ROOT_W-1:0], srad_reg[2*ROOT_W-1 -: 2]};
    assign stest  = {sroot_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_start) begin
            srad_reg  <= (2*ROOT_W)'(dq_reg);
            srem_reg  <= '0;
            sroot_reg <= '0;
            sstep_reg <= '0;
        end else if (cmd.sqrt_step) begin
            srad_reg <= {srad_reg[2*ROOT_W-3:0], 2'b00};
            if (strial >= stest) begin
                srem_reg  <= strial - stest;
                sroot_reg <= {sroot_reg[ROOT_W-2:0], 1'b1};
            end else begin
                srem_reg  <= strial;
                sroot_reg <= {sroot_reg[ROOT_W-2:0], 1'b0};
            end
            sstep_reg <= sstep_reg + 1'b1;
        end
    end

    assign status.sqrt_done = (32'(sstep_reg) == ROOT_W);

    // Offset correction
    logic [LEVEL_W-1:0] rms, corrected;
    assign rms       = sroot_reg[LEVEL_W-1:0];
    assign corrected = (rms > LEVEL_W'(dc_offset)) ? rms - LEVEL_W'(dc_offset) : '0;

    // Level ring with valid bits, running total and fill count
    logic [LEVEL_W-1:0] ring_reg [AVG_DEPTH];
    logic [AVG_DEPTH-1:0] ring_valid_reg;
    logic [TOT_W-1:0]   total_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [LEVEL_W-1:0] old_level;

    assign old_level = ring_valid_reg[pos_reg] ? ring_reg[pos_reg] : '0;

    always_ff @(posedge aclk) begin
        if (cmd.ring_update) begin
            ring_reg[pos_reg] <= corrected;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_valid_reg <= '0;
            total_reg      <= '0;
            pos_reg        <= '0;
            fill_reg       <= '0;
        end else if (cmd.ring_update) begin
            ring_valid_reg[pos_reg] <= 1'b1;
            total_reg <= total_reg - TOT_W'(old_level) + TOT_W'(corrected);
            pos_reg   <= (32'(pos_reg) == AVG_DEPTH - 1) ? '0 : pos_reg + 1'b1;
            if (32'(fill_reg) < AVG_DEPTH) begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // Average divider: total / fill, one bit a cycle
    logic [TOT_W-1:0]   aq_reg;
    logic [FILL_W:0]    arem_reg;
    logic [ASTEP_W-1:0] astep_reg;
    logic [FILL_W:0]    atrial;
    logic [TOT_W-1:0]   atot;

    assign atot   = total_reg - TOT_W'(old_level) + TOT_W'(corrected);
    assign atrial = {arem_reg[FILL_W-1:0], aq_reg[TOT_W-1]};

    always_ff @(posedge aclk) begin
        if (cmd.avg_start) begin
            aq_reg    <= atot;
            arem_reg  <= '0;
            astep_reg <= '0;
        end else if (cmd.avg_step) begin
            if (atrial >= {1'b0, fill_reg}) begin
                arem_reg <= atrial - {1'b0, fill_reg};
                aq_reg   <= {aq_reg[TOT_W-2:0], 1'b1};
            end else begin
                arem_reg <= atrial;
                aq_reg   <= {aq_reg[TOT_W-2:0], 1'b0};
            end
            astep_reg <= astep_reg + 1'b1;
        end
    end

    assign status.avg_done = (32'(astep_reg) == TOT_W);

    // Output register; corrected level is held from the ring step
    logic [LEVEL_W-1:0] corr_hold_reg;
    logic               out_valid_reg;
    logic [55:0]        out_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.ring_update) begin
            corr_hold_reg <= corrected;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= {3'd0, 5'(fill_reg), aq_reg[LEVEL_W-1:0],
                             corr_hold_reg, rms};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign out_busy = out_valid_reg && !m_tready;

endmodule

/* hw/rtl/frame_rms_moving_average_unit.sv */
// A sample that leaves its frame open is finished after the check state; a closing
// sample shows its result after the check, mean divider, square root, ring step,
// average divider and output load states, in that order.
// A new sample is taken only after the last has passed the check; after a closing
// sample the next one is taken once the result has been loaded into a free register.
// Reset: aresetn synchronous, active low; clears the frame, ring and output.
// ----------------------------------------------------------------------------
// frame_rms_moving_average_unit: frame RMS level meter with moving average
// Streams samples in, emits one level result per closed frame.
// ----------------------------------------------------------------------------
module frame_rms_moving_average_unit #(
    parameter int AVG_DEPTH = 16,
    parameter int FRAME_MAX = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tlast,   // last_of_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [15:0] frame_rms, [31:16] corrected_level,
                                   // [47:32] average_level, [52:48] frames_in_average
);
    import frma_pkg::*;

    frma_cmd_t    cmd;
    frma_status_t status;
    logic         out_busy;
    logic [OFFSET_W-1:0] dc_offset_reg;

    // Offset register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dc_offset_reg <= '0;
        end else if (cfg_we) begin
            dc_offset_reg <= cfg_wdata;
        end
    end

    frma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_busy (out_busy),
        .status   (status),
        .cmd      (cmd)
    );

    frma_datapath #(
        .AVG_DEPTH (AVG_DEPTH),
        .FRAME_MAX (FRAME_MAX)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_sample (s_tdata),
        .in_last   (s_tlast),
        .dc_offset (dc_offset_reg),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .out_busy  (out_busy)
    );

endmodule

/* hw/rtl/frma_checker.sv */
// ----------------------------------------------------------------------------
// frma_checker: port-level checks of the level meter
// Watches the result stream and the sample handshake.
// ----------------------------------------------------------------------------
module frma_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);
    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // No sample taken the cycle after a transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("back to back sample transfer");

    // Corrected level never exceeds frame RMS
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:16] <= m_tdata[15:0])
        else $error("corrected above rms");

    // Fill count is at least one on every result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[52:48] != 5'd0)
        else $error("empty average");
endmodule

bind frame_rms_moving_average_unit frma_checker u_frma_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
